@@ sv/nkrt_pkg.sv @@
// Shared types, codes and defaults for the name-keyed registry table.
`default_nettype none
package nkrt_pkg;

    localparam int ENTRIES_DEF      = 16;
    localparam int NAME_BYTES_DEF   = 32;
    localparam int NAME_FIELD_BYTES = 32;
    localparam int WORDS_PER_NAME   = 4;
    localparam int VALUE_BITS       = 96;
    localparam logic [11:0] MIN_PAYLOAD_RESET = 12'd60;

    typedef enum logic [1:0] {
        KIND_REGISTER   = 2'd0,
        KIND_LOOKUP     = 2'd1,
        KIND_UNREGISTER = 2'd2,
        KIND_UNKNOWN    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD       = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_ACT,
        S_APPEND,
        S_LREAD,
        S_SHIFT,
        S_FIN
    } t_state;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] name_bytes_0_7;
        logic [63:0] name_bytes_8_15;
        logic [63:0] name_bytes_16_23;
        logic [63:0] name_bytes_24_31;
        logic [31:0] reg_portal_id;
        logic [31:0] reg_mailbox_tid;
        logic [31:0] reg_mail_magic;
        logic [11:0] payload_size;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [31:0] found_portal_id;
        logic [31:0] found_mailbox_tid;
        logic [31:0] found_mail_magic;
    } t_rsp;

    typedef logic [WORDS_PER_NAME-1:0][63:0] t_key;

endpackage
`default_nettype wire

@@ sv/nkrt_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module nkrt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ sv/nkrt_key.sv @@
// Name key extraction and request validity check.
`default_nettype none
module nkrt_key
    import nkrt_pkg::*;
#(
    parameter int NAME_BYTES = NAME_BYTES_DEF
) (
    input  wire t_req        i_req,
    input  wire logic [11:0] i_min,
    output t_key             o_key,
    output logic             o_bad
);

    localparam logic [NAME_FIELD_BYTES-1:0] NMASK =
        {NAME_FIELD_BYTES{1'b1}} >> (NAME_FIELD_BYTES - NAME_BYTES);

    logic [NAME_FIELD_BYTES*8-1:0] names;
    logic [NAME_FIELD_BYTES*8-1:0] flat;
    logic [NAME_FIELD_BYTES-1:0]   zmask;

    assign names = {i_req.name_bytes_24_31, i_req.name_bytes_16_23,
                    i_req.name_bytes_8_15, i_req.name_bytes_0_7};

    always_comb begin
        for (int j = 0; j < NAME_FIELD_BYTES; j++) begin
            zmask[j] = (names[j*8 +: 8] == 8'd0);
        end
        for (int j = 0; j < NAME_FIELD_BYTES; j++) begin
            if ((zmask & ((NAME_FIELD_BYTES'(1) << j) - NAME_FIELD_BYTES'(1))) == '0) begin
                flat[j*8 +: 8] = names[j*8 +: 8];
            end else begin
                flat[j*8 +: 8] = 8'd0;
            end
        end
    end

    assign o_key = flat;
    assign o_bad = (i_req.payload_size < i_min) || zmask[0] || ((zmask & NMASK) == '0)
                   || (i_req.kind == KIND_UNKNOWN);

endmodule
`default_nettype wire

@@ sv/name_keyed_registry_table.sv @@
// Name-keyed registry table: sequencer, word comparator and entry stores.
//
// Request channel: i_req_valid / o_req_stall carry one t_req; it is taken at
// an edge where i_req_valid is high and o_req_stall is low. Response channel:
// o_rsp_valid / i_rsp_stall carry one t_rsp per request, in request order.
// Configuration: i_cfg_valid / o_cfg_ready write min_payload_bytes; ready out of reset.
//
// One request is worked at a time. The name store is scanned one 64-bit word
// per cycle through a single comparator; an empty table skips the scan. A
// rejected request goes from the check straight to the response. After the
// scan, a lookup or unregister that misses, an overwrite or a full table is
// answered from the action step; a lookup hit first reads the value store, an
// append writes the value and the four name words, and an unregister hit moves
// every later entry down (none for the last entry). The request stall drops
// in the same cycle as the response goes valid. The response sits in an
// output register, so a new request is taken while the previous response is
// still stalled; completion waits only if that register is still full.
// Reset empties the table, restores min_payload_bytes to 60 and holds the
// request stall; no clearing pass is needed since only filled entries are read.
`default_nettype none
module name_keyed_registry_table
    import nkrt_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int NAME_BYTES = NAME_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_req_valid,
    output logic             o_req_stall,
    input  wire t_req        i_req,
    output logic             o_rsp_valid,
    input  wire logic        i_rsp_stall,
    output t_rsp             o_rsp,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [11:0] i_cfg_data
);

    localparam int EW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int NDEPTH = ENTRIES * WORDS_PER_NAME;
    localparam int NAW    = $clog2(NDEPTH);
    localparam int CW     = $clog2(ENTRIES + 1);
    localparam int SW     = CW + 2;

    t_state              r_state, n_state;
    t_req                r_req;
    logic [11:0]         r_min;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [SW-1:0]       r_ip, n_ip;
    logic [SW-1:0]       r_cp, n_cp;
    logic                r_cp_vld, n_cp_vld;
    logic                r_mis, n_mis;
    logic                r_hit, n_hit;
    logic [EW-1:0]       r_e, n_e;
    logic [1:0]          r_wp, n_wp;
    t_status             r_status, n_status;
    logic [VALUE_BITS-1:0] r_found, n_found;
    logic                r_ovld, n_ovld;
    t_rsp                r_rsp, n_rsp;

    t_key                w_key;
    logic                w_bad;

    logic                nm_we;
    logic [NAW-1:0]      nm_waddr, nm_raddr;
    logic [63:0]         nm_wdata, nm_rdata;
    logic                val_we;
    logic [EW-1:0]       val_waddr, val_raddr;
    logic [VALUE_BITS-1:0] val_wdata, val_rdata;

    logic [SW-1:0]       scan_lim, shift_lim, ip_plus4;
    logic [1:0]          cp_word;
    logic [EW-1:0]       cp_ent, ip_ent;
    logic                word_miss, miss, issue;

    nkrt_key #(
        .NAME_BYTES(NAME_BYTES)
    ) u_key (
        .i_req(r_req),
        .i_min(r_min),
        .o_key(w_key),
        .o_bad(w_bad)
    );

    nkrt_ram #(
        .WIDTH(64),
        .DEPTH(NDEPTH)
    ) u_name_ram (
        .i_clk  (i_clk),
        .i_we   (nm_we),
        .i_waddr(nm_waddr),
        .i_wdata(nm_wdata),
        .i_raddr(nm_raddr),
        .o_rdata(nm_rdata)
    );

    nkrt_ram #(
        .WIDTH(VALUE_BITS),
        .DEPTH(ENTRIES)
    ) u_val_ram (
        .i_clk  (i_clk),
        .i_we   (val_we),
        .i_waddr(val_waddr),
        .i_wdata(val_wdata),
        .i_raddr(val_raddr),
        .o_rdata(val_rdata)
    );

    assign scan_lim  = {r_cnt, 2'b00};
    assign shift_lim = {r_cnt - CW'(1), 2'b00};
    assign ip_plus4  = r_ip + SW'(WORDS_PER_NAME);
    assign cp_word   = r_cp[1:0];
    assign cp_ent    = EW'(r_cp[SW-1:2]);
    assign ip_ent    = EW'(r_ip[SW-1:2]);
    assign word_miss = (nm_rdata != w_key[cp_word]);
    assign miss      = r_mis || word_miss;

    assign o_req_stall = !i_rst_n || (r_state != S_IDLE);
    assign o_rsp_valid = r_ovld;
    assign o_rsp       = r_rsp;
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_min    <= MIN_PAYLOAD_RESET;
            r_ovld   <= 1'b0;
            r_cp_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovld   <= n_ovld;
            r_cp_vld <= n_cp_vld;
            if (i_cfg_valid) begin
                r_min <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req_valid) begin
            r_req <= i_req;
        end
        r_ip     <= n_ip;
        r_cp     <= n_cp;
        r_mis    <= n_mis;
        r_hit    <= n_hit;
        r_e      <= n_e;
        r_wp     <= n_wp;
        r_status <= n_status;
        r_found  <= n_found;
        r_rsp    <= n_rsp;
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_ip      = r_ip;
        n_cp      = r_cp;
        n_cp_vld  = r_cp_vld;
        n_mis     = r_mis;
        n_hit     = r_hit;
        n_e       = r_e;
        n_wp      = r_wp;
        n_status  = r_status;
        n_found   = r_found;
        n_rsp     = r_rsp;
        n_ovld    = r_ovld && i_rsp_stall;
        issue     = 1'b0;
        nm_we     = 1'b0;
        nm_waddr  = r_cp[NAW-1:0];
        nm_wdata  = nm_rdata;
        nm_raddr  = r_ip[NAW-1:0];
        val_we    = 1'b0;
        val_waddr = r_e;
        val_wdata = {r_req.reg_portal_id, r_req.reg_mailbox_tid, r_req.reg_mail_magic};
        val_raddr = r_e;

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_status = ST_OK;
                n_found  = '0;
                n_ip     = '0;
                n_cp_vld = 1'b0;
                n_mis    = 1'b0;
                n_hit    = 1'b0;
                if (w_bad) begin
                    n_status = ST_BAD;
                    n_state  = S_FIN;
                end else if (r_cnt == '0) begin
                    n_state = S_ACT;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                issue    = (r_ip < scan_lim);
                n_cp     = r_ip;
                n_cp_vld = issue;
                if (issue) begin
                    n_ip = r_ip + SW'(1);
                end
                if (r_cp_vld) begin
                    if (cp_word == 2'd3) begin
                        n_mis = 1'b0;
                        if (!miss) begin
                            n_hit   = 1'b1;
                            n_e     = cp_ent;
                            n_state = S_ACT;
                        end else if (r_cp + SW'(1) == scan_lim) begin
                            n_state = S_ACT;
                        end
                    end else begin
                        n_mis = miss;
                    end
                end
            end
            S_ACT: begin
                n_cp_vld = 1'b0;
                case (r_req.kind)
                    KIND_REGISTER: begin
                        if (r_hit) begin
                            val_we  = 1'b1;
                            n_state = S_FIN;
                        end else if (r_cnt >= CW'(ENTRIES)) begin
                            n_status = ST_FULL;
                            n_state  = S_FIN;
                        end else begin
                            n_wp    = 2'd0;
                            n_e     = EW'(r_cnt);
                            n_state = S_APPEND;
                        end
                    end
                    KIND_LOOKUP: begin
                        if (r_hit) begin
                            n_state = S_LREAD;
                        end else begin
                            n_status = ST_NOT_FOUND;
                            n_state  = S_FIN;
                        end
                    end
                    KIND_UNREGISTER: begin
                        if (r_hit) begin
                            n_ip    = SW'({r_e, 2'b00});
                            n_state = S_SHIFT;
                        end else begin
                            n_status = ST_NOT_FOUND;
                            n_state  = S_FIN;
                        end
                    end
                    default: begin
                        n_status = ST_BAD;
                        n_state  = S_FIN;
                    end
                endcase
            end
            S_APPEND: begin
                nm_we    = 1'b1;
                nm_waddr = NAW'({r_e, r_wp});
                nm_wdata = w_key[r_wp];
                val_we   = (r_wp == 2'd0);
                n_wp     = r_wp + 2'd1;
                if (r_wp == 2'd3) begin
                    n_cnt   = r_cnt + CW'(1);
                    n_state = S_FIN;
                end
            end
            S_LREAD: begin
                n_found = val_rdata;
                n_state = S_FIN;
            end
            S_SHIFT: begin
                issue     = (r_ip < shift_lim);
                nm_raddr  = ip_plus4[NAW-1:0];
                val_raddr = ip_ent + EW'(1);
                n_cp      = r_ip;
                n_cp_vld  = issue;
                if (issue) begin
                    n_ip = r_ip + SW'(1);
                end
                if (r_cp_vld) begin
                    nm_we = 1'b1;
                    if (cp_word == 2'd0) begin
                        val_we    = 1'b1;
                        val_waddr = cp_ent;
                        val_wdata = val_rdata;
                    end
                end
                if (!issue && !r_cp_vld) begin
                    n_cnt   = r_cnt - CW'(1);
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_ovld || !i_rsp_stall) begin
                    n_ovld                  = 1'b1;
                    n_rsp.status            = r_status;
                    n_rsp.found_portal_id   = r_found[95:64];
                    n_rsp.found_mailbox_tid = r_found[63:32];
                    n_rsp.found_mail_magic  = r_found[31:0];
                    n_state                 = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ sv/nkrt_checker.sv @@
// Port-level checker for the registry table, bound to the top level.
`default_nettype none
module nkrt_checker
    import nkrt_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_req_valid,
    input wire logic o_req_stall,
    input wire logic o_rsp_valid,
    input wire logic i_rsp_stall,
    input wire t_rsp o_rsp
);

    a_reset_clears_rsp: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid)
        else $error("response valid after reset");

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && !o_req_stall |=> o_req_stall)
        else $error("request taken while previous one still in work");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && i_rsp_stall |=> o_rsp_valid && $stable(o_rsp))
        else $error("stalled response changed");

    a_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status != ST_OK |->
            o_rsp.found_portal_id == '0 && o_rsp.found_mailbox_tid == '0
            && o_rsp.found_mail_magic == '0)
        else $error("found values nonzero on failed request");

endmodule

bind name_keyed_registry_table nkrt_checker u_nkrt_checker (.*);
`default_nettype wire
